// File: hdl/y4m_pkg.sv
// Package for the YUV4MPEG2 luma extractor: parser phases, tag codes,
// result kinds and the character constants and token tables it matches.
// No dependencies.
`default_nettype none

package y4m_pkg;

    typedef enum logic [3:0] {
        PH_MAGIC_WS  = 4'd0,
        PH_MAGIC     = 4'd1,
        PH_HDR_SEL   = 4'd2,
        PH_HDR_VAL   = 4'd3,
        PH_FRM_WS    = 4'd4,
        PH_FRM_MATCH = 4'd5,
        PH_FRM_SEL   = 4'd6,
        PH_FRM_VAL   = 4'd7,
        PH_LUMA      = 4'd8,
        PH_CHROMA    = 4'd9,
        PH_ERROR     = 4'd10
    } t_phase;

    typedef enum logic [2:0] {
        TAG_NONE = 3'd0,
        TAG_W    = 3'd1,
        TAG_H    = 3'd2,
        TAG_C    = 3'd3,
        TAG_I    = 3'd4,
        TAG_SKIP = 3'd5
    } t_tag;

    typedef enum logic [1:0] {
        KIND_LUMA   = 2'd0,
        KIND_FRAME  = 2'd1,
        KIND_HEADER = 2'd2,
        KIND_ERROR  = 2'd3
    } t_kind;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_W  = 8'h57;
    localparam logic [7:0] CH_UP_H  = 8'h48;
    localparam logic [7:0] CH_UP_C  = 8'h43;
    localparam logic [7:0] CH_UP_I  = 8'h49;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_P  = 8'h70;

    localparam logic [3:0] MAGIC_LEN  = 4'd9;
    localparam logic [3:0] FRAME_LEN  = 4'd5;
    localparam logic [3:0] CHROMA_LEN = 4'd7;

    // Characters of "YUV4MPEG2".
    function automatic logic [7:0] magic_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h59;
            4'd1:    ch = 8'h55;
            4'd2:    ch = 8'h56;
            4'd3:    ch = 8'h34;
            4'd4:    ch = 8'h4D;
            4'd5:    ch = 8'h50;
            4'd6:    ch = 8'h45;
            4'd7:    ch = 8'h47;
            4'd8:    ch = 8'h32;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Characters of "FRAME".
    function automatic logic [7:0] frame_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h46;
            4'd1:    ch = 8'h52;
            4'd2:    ch = 8'h41;
            4'd3:    ch = 8'h4D;
            4'd4:    ch = 8'h45;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Characters of "420jpeg".
    function automatic logic [7:0] chroma_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h34;
            4'd1:    ch = 8'h32;
            4'd2:    ch = 8'h30;
            4'd3:    ch = 8'h6A;
            4'd4:    ch = 8'h70;
            4'd5:    ch = 8'h65;
            4'd6:    ch = 8'h67;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_ws(input logic [7:0] ch);
        return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) ||
               (ch == CH_VT) || (ch == CH_FF) || (ch == CH_CR);
    endfunction

endpackage

`default_nettype wire

// File: hdl/y4m_luma_extractor.sv
// Top level of the YUV4MPEG2 luma extractor: byte-wide stream parser with a
// registered result stage. Depends on y4m_pkg.
`default_nettype none

// The block takes one stream byte per clock and gives at most one result per
// byte, registered, in the cycle after the byte is accepted. The parser state
// and the output register are updated in the same cycle, so a byte can be
// accepted in every cycle; the input is stalled only while a result waits in
// the output register and the output side stalls. The first result is the
// stream header (kind 2, with width and height) or a format error (kind 3);
// then each frame gives a frame-begin result and one result per luma byte,
// while chroma bytes are dropped. An error is final: all later bytes are
// taken and ignored until reset. The chroma byte count is 2*floor(w*h/4),
// registered from the product w*h, ready well before the first frame.
module y4m_luma_extractor #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic [7:0]   i_data_byte,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output y4m_pkg::t_kind    o_kind,
    output logic [7:0]        o_pixel,
    output logic [11:0]       o_column,
    output logic [11:0]       o_row,
    output logic              o_last_of_frame,
    output logic [12:0]       o_frame_width,
    output logic [12:0]       o_frame_height
);
    import y4m_pkg::*;

    localparam logic [16:0] MaxDimW = 17'(MAX_DIM);

    t_phase      r_phase, n_phase;
    t_tag        r_tag, n_tag;
    logic [3:0]  r_pos, n_pos;
    logic [12:0] r_acc, n_acc;
    logic [12:0] r_width, n_width;
    logic [12:0] r_height, n_height;
    logic        r_seen_w, n_seen_w;
    logic        r_seen_h, n_seen_h;
    logic [11:0] r_col, n_col;
    logic [11:0] r_row, n_row;
    logic [23:0] r_chroma_total;
    logic [23:0] r_chroma_cnt, n_chroma_cnt;

    logic        r_out_valid;
    t_kind       r_kind;
    logic [7:0]  r_pixel;
    logic [11:0] r_column;
    logic [11:0] r_row_out;
    logic        r_last;
    logic [12:0] r_fw;
    logic [12:0] r_fh;

    logic        in_fire;
    logic        res_valid;
    t_kind       res_kind;
    logic [7:0]  res_pixel;
    logic [11:0] res_column;
    logic [11:0] res_row;
    logic        res_last;
    logic [12:0] res_fw;
    logic [12:0] res_fh;

    logic        do_fail;
    logic        do_hdr_done;
    logic        do_frm_start;
    logic        val_ok;
    logic        end_ok;
    logic        is_delim;
    logic [3:0]  pos;
    logic [16:0] acc_new;
    logic [12:0] col_inc;
    logic [12:0] row_inc;
    logic        last;
    logic [25:0] area;
    logic [7:0]  c;

    assign c          = i_data_byte;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_fire    = i_in_valid && !o_in_stall;
    assign area       = r_width * r_height;

    always_comb begin
        n_phase      = r_phase;
        n_tag        = r_tag;
        n_pos        = r_pos;
        n_acc        = r_acc;
        n_width      = r_width;
        n_height     = r_height;
        n_seen_w     = r_seen_w;
        n_seen_h     = r_seen_h;
        n_col        = r_col;
        n_row        = r_row;
        n_chroma_cnt = r_chroma_cnt;

        res_valid    = 1'b0;
        res_kind     = KIND_LUMA;
        res_pixel    = 8'd0;
        res_column   = 12'd0;
        res_row      = 12'd0;
        res_last     = 1'b0;
        res_fw       = 13'd0;
        res_fh       = 13'd0;

        do_fail      = 1'b0;
        do_hdr_done  = 1'b0;
        do_frm_start = 1'b0;
        val_ok       = 1'b0;
        end_ok       = 1'b0;
        is_delim     = (c == CH_SPACE) || (c == CH_LF);
        pos          = r_pos;
        acc_new      = 17'({4'd0, r_acc} * 17'd10) + 17'(c - CH_ZERO);
        col_inc      = {1'b0, r_col} + 13'd1;
        row_inc      = {1'b0, r_row} + 13'd1;
        last         = (col_inc == r_width) && (row_inc == r_height);

        unique case (r_phase)
            PH_MAGIC_WS, PH_MAGIC: begin
                if (r_phase == PH_MAGIC_WS) begin
                    pos = 4'd0;
                end
                if (r_phase == PH_MAGIC_WS && is_ws(c)) begin
                    n_phase = r_phase;
                end else if (pos < MAGIC_LEN) begin
                    if (c != magic_char(pos)) begin
                        do_fail = 1'b1;
                    end else begin
                        n_pos   = pos + 4'd1;
                        n_phase = PH_MAGIC;
                    end
                end else if (c == CH_SPACE) begin
                    n_phase = PH_HDR_SEL;
                end else if (c == CH_LF) begin
                    do_hdr_done = 1'b1;
                end else begin
                    do_fail = 1'b1;
                end
            end
            PH_HDR_SEL, PH_FRM_SEL: begin
                if (c == CH_SPACE) begin
                    n_phase = r_phase;
                end else if (c == CH_LF) begin
                    do_hdr_done  = (r_phase == PH_HDR_SEL);
                    do_frm_start = (r_phase == PH_FRM_SEL);
                end else begin
                    n_pos   = 4'd0;
                    n_acc   = 13'd0;
                    n_phase = (r_phase == PH_HDR_SEL) ? PH_HDR_VAL : PH_FRM_VAL;
                    if (c == CH_UP_I) begin
                        n_tag = TAG_I;
                    end else if (c == CH_UP_X) begin
                        n_tag = TAG_SKIP;
                    end else if (r_phase == PH_HDR_SEL && c == CH_UP_W) begin
                        n_tag = TAG_W;
                    end else if (r_phase == PH_HDR_SEL && c == CH_UP_H) begin
                        n_tag = TAG_H;
                    end else if (r_phase == PH_HDR_SEL && c == CH_UP_C) begin
                        n_tag = TAG_C;
                    end else if (r_phase == PH_HDR_SEL &&
                                 (c == CH_UP_F || c == CH_UP_A)) begin
                        n_tag = TAG_SKIP;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
            end
            PH_HDR_VAL, PH_FRM_VAL: begin
                if (is_delim) begin
                    case (r_tag)
                        TAG_W: begin
                            end_ok = (r_pos == 4'd1);
                            if (end_ok) begin
                                n_width  = r_acc;
                                n_seen_w = 1'b1;
                            end
                        end
                        TAG_H: begin
                            end_ok = (r_pos == 4'd1);
                            if (end_ok) begin
                                n_height = r_acc;
                                n_seen_h = 1'b1;
                            end
                        end
                        TAG_C:    end_ok = (r_pos == CHROMA_LEN);
                        TAG_I:    end_ok = (r_pos == 4'd1);
                        TAG_SKIP: end_ok = 1'b1;
                        default:  end_ok = 1'b0;
                    endcase
                    if (!end_ok) begin
                        do_fail = 1'b1;
                    end else if (c == CH_LF) begin
                        do_hdr_done  = (r_phase == PH_HDR_VAL);
                        do_frm_start = (r_phase == PH_FRM_VAL);
                    end else begin
                        n_phase = (r_phase == PH_HDR_VAL) ? PH_HDR_SEL : PH_FRM_SEL;
                    end
                end else begin
                    case (r_tag)
                        TAG_W, TAG_H: begin
                            val_ok = (c >= CH_ZERO) && (c <= CH_NINE) &&
                                     (acc_new <= MaxDimW);
                            if (val_ok) begin
                                n_acc = acc_new[12:0];
                                n_pos = 4'd1;
                            end
                        end
                        TAG_C: begin
                            val_ok = (r_pos < CHROMA_LEN) && (c == chroma_char(r_pos));
                            if (val_ok) begin
                                n_pos = r_pos + 4'd1;
                            end
                        end
                        TAG_I: begin
                            val_ok = (r_pos == 4'd0) && (c == CH_LO_P);
                            if (val_ok) begin
                                n_pos = 4'd1;
                            end
                        end
                        TAG_SKIP: val_ok = 1'b1;
                        default:  val_ok = 1'b0;
                    endcase
                    do_fail = !val_ok;
                end
            end
            PH_FRM_WS, PH_FRM_MATCH: begin
                if (r_phase == PH_FRM_WS) begin
                    pos = 4'd0;
                end
                if (r_phase == PH_FRM_WS && is_ws(c)) begin
                    n_phase = r_phase;
                end else if (pos < FRAME_LEN) begin
                    if (c != frame_char(pos)) begin
                        do_fail = 1'b1;
                    end else begin
                        n_pos   = pos + 4'd1;
                        n_phase = PH_FRM_MATCH;
                    end
                end else if (c == CH_SPACE) begin
                    n_phase = PH_FRM_SEL;
                end else if (c == CH_LF) begin
                    do_frm_start = 1'b1;
                end else begin
                    do_fail = 1'b1;
                end
            end
            PH_LUMA: begin
                res_valid  = 1'b1;
                res_kind   = KIND_LUMA;
                res_pixel  = c;
                res_column = r_col;
                res_row    = r_row;
                res_last   = last;
                if (col_inc >= r_width) begin
                    n_col = 12'd0;
                    n_row = row_inc[11:0];
                end else begin
                    n_col = col_inc[11:0];
                end
                if (last) begin
                    n_chroma_cnt = 24'd0;
                    n_phase = (r_chroma_total != 24'd0) ? PH_CHROMA : PH_FRM_WS;
                end
            end
            PH_CHROMA: begin
                n_chroma_cnt = r_chroma_cnt + 24'd1;
                if (n_chroma_cnt >= r_chroma_total) begin
                    n_phase = PH_FRM_WS;
                end
            end
            PH_ERROR: begin
                n_phase = PH_ERROR;
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase

        if (do_hdr_done) begin
            if (!n_seen_w || !n_seen_h) begin
                do_fail = 1'b1;
            end else begin
                n_phase   = PH_FRM_WS;
                res_valid = 1'b1;
                res_kind  = KIND_HEADER;
                res_fw    = n_width;
                res_fh    = n_height;
            end
        end

        if (do_frm_start) begin
            n_col        = 12'd0;
            n_row        = 12'd0;
            n_chroma_cnt = 24'd0;
            n_phase      = (r_width == 13'd0 || r_height == 13'd0) ? PH_FRM_WS : PH_LUMA;
            res_valid    = 1'b1;
            res_kind     = KIND_FRAME;
        end

        if (do_fail) begin
            n_phase   = PH_ERROR;
            res_valid = 1'b1;
            res_kind  = KIND_ERROR;
            res_fw    = 13'd0;
            res_fh    = 13'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_MAGIC_WS;
            r_tag        <= TAG_NONE;
            r_pos        <= 4'd0;
            r_acc        <= 13'd0;
            r_width      <= 13'd0;
            r_height     <= 13'd0;
            r_seen_w     <= 1'b0;
            r_seen_h     <= 1'b0;
            r_col        <= 12'd0;
            r_row        <= 12'd0;
            r_chroma_cnt <= 24'd0;
        end else if (in_fire) begin
            r_phase      <= n_phase;
            r_tag        <= n_tag;
            r_pos        <= n_pos;
            r_acc        <= n_acc;
            r_width      <= n_width;
            r_height     <= n_height;
            r_seen_w     <= n_seen_w;
            r_seen_h     <= n_seen_h;
            r_col        <= n_col;
            r_row        <= n_row;
            r_chroma_cnt <= n_chroma_cnt;
        end
    end

    // Two chroma planes of floor(w*h/4) bytes each.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chroma_total <= 24'd0;
        end else begin
            r_chroma_total <= {area[24:2], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= in_fire && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && res_valid) begin
            r_kind    <= res_kind;
            r_pixel   <= res_pixel;
            r_column  <= res_column;
            r_row_out <= res_row;
            r_last    <= res_last;
            r_fw      <= res_fw;
            r_fh      <= res_fh;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_pixel         = r_pixel;
    assign o_column        = r_column;
    assign o_row           = r_row_out;
    assign o_last_of_frame = r_last;
    assign o_frame_width   = r_fw;
    assign o_frame_height  = r_fh;

endmodule

`default_nettype wire

// File: hdl/y4m_checker.sv
// Port-level checks for the YUV4MPEG2 luma extractor and the bind that
// attaches them to the top level. Depends on y4m_pkg.
`default_nettype none

module y4m_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_in_stall,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire y4m_pkg::t_kind o_kind,
    input wire logic [7:0]     o_pixel,
    input wire logic [11:0]    o_column,
    input wire logic [11:0]    o_row,
    input wire logic           o_last_of_frame
);
    import y4m_pkg::*;

    // The input is held back only while a result waits and is stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a waiting result");

    // A stalled result keeps its kind.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_kind)))
        else $error("stalled result changed");

    // Nothing follows a delivered format error.
    a_err_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_kind == KIND_ERROR) |=> !o_out_valid)
        else $error("result after a format error");

    // Pixel fields are zero on every result that is not a luma item.
    a_pixel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != KIND_LUMA) |->
            (o_pixel == 8'd0 && o_column == 12'd0 && o_row == 12'd0 &&
             !o_last_of_frame))
        else $error("pixel fields set on a non-luma result");

endmodule

bind y4m_luma_extractor y4m_checker u_y4m_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_kind          (o_kind),
    .o_pixel         (o_pixel),
    .o_column        (o_column),
    .o_row           (o_row),
    .o_last_of_frame (o_last_of_frame)
);

`default_nettype wire

// File: tb/tb_y4m_luma_extractor.sv
// Self-checking testbench for y4m_luma_extractor: drives one YUV4MPEG2 stream
// byte by byte under random idling and stalls and checks every result against
// a scoreboard that parses the same stream. Depends on y4m_pkg and the RTL.
`timescale 1ns / 100ps

import y4m_pkg::*;

typedef struct packed {
    t_kind       kind;
    logic [7:0]  pixel;
    logic [11:0] column;
    logic [11:0] row;
    logic        last_of_frame;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
} t_result;

class t_scoreboard;
    t_result     expected_results[$];
    int          mismatches;
    int          results_checked;
    int unsigned dim_limit;
    string       magic_text;
    string       frame_text;
    string       chroma_text;
    t_phase      parse_phase;
    t_tag        field_tag;
    int unsigned match_pos;
    int unsigned accum;
    int unsigned width_val;
    int unsigned height_val;
    int unsigned col_count;
    int unsigned row_count;
    int unsigned chroma_total;
    int unsigned chroma_count;
    bit          seen_w;
    bit          seen_h;
    bit          stream_failed;

    function new(int unsigned limit);
        dim_limit       = limit;
        magic_text      = "YUV4MPEG2";
        frame_text      = "FRAME";
        chroma_text     = "420jpeg";
        mismatches      = 0;
        results_checked = 0;
        parse_phase     = PH_MAGIC_WS;
        field_tag       = TAG_NONE;
        match_pos       = 0;
        accum           = 0;
        width_val       = 0;
        height_val      = 0;
        col_count       = 0;
        row_count       = 0;
        chroma_total    = 0;
        chroma_count    = 0;
        seen_w          = 1'b0;
        seen_h          = 1'b0;
        stream_failed   = 1'b0;
    endfunction

    function bit blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

    function void append_expected(t_result r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function void push_kind(t_kind k);
        t_result r;
        r      = '0;
        r.kind = k;
        append_expected(r);
    endfunction

    function void format_error();
        stream_failed = 1'b1;
        parse_phase   = PH_ERROR;
        push_kind(KIND_ERROR);
    endfunction

    function void open_tag(t_tag tag, t_phase next_phase);
        field_tag   = tag;
        match_pos   = 0;
        accum       = 0;
        parse_phase = next_phase;
    endfunction

    function bit take_value_byte(logic [7:0] c);
        case (field_tag)
            TAG_W, TAG_H: begin
                if (c < CH_ZERO || c > CH_NINE) return 1'b0;
                accum = accum * 10 + (c - CH_ZERO);
                if (accum > dim_limit) return 1'b0;
                match_pos = 1;
                return 1'b1;
            end
            TAG_C: begin
                if (match_pos < chroma_text.len() && c == chroma_text[match_pos]) begin
                    match_pos++;
                    return 1'b1;
                end
                return 1'b0;
            end
            TAG_I: begin
                if (match_pos == 0 && c == CH_LO_P) begin
                    match_pos = 1;
                    return 1'b1;
                end
                return 1'b0;
            end
            TAG_SKIP: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function bit close_value();
        case (field_tag)
            TAG_W: begin
                if (match_pos != 1) return 1'b0;
                width_val = accum;
                seen_w    = 1'b1;
                return 1'b1;
            end
            TAG_H: begin
                if (match_pos != 1) return 1'b0;
                height_val = accum;
                seen_h     = 1'b1;
                return 1'b1;
            end
            TAG_C: return match_pos == chroma_text.len();
            TAG_I: return match_pos == 1;
            TAG_SKIP: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function void close_header();
        t_result r;
        if (!seen_w || !seen_h) begin
            format_error();
            return;
        end
        chroma_total   = ((width_val * height_val) / 4) * 2;
        parse_phase    = PH_FRM_WS;
        r              = '0;
        r.kind         = KIND_HEADER;
        r.frame_width  = width_val[12:0];
        r.frame_height = height_val[12:0];
        append_expected(r);
    endfunction

    function void start_frame();
        col_count    = 0;
        row_count    = 0;
        chroma_count = 0;
        if (width_val == 0 || height_val == 0) begin
            if (chroma_total != 0) parse_phase = PH_CHROMA;
            else parse_phase = PH_FRM_WS;
        end else begin
            parse_phase = PH_LUMA;
        end
        push_kind(KIND_FRAME);
    endfunction

    function void note_byte(logic [7:0] c);
        t_result r;
        bit      last_px;
        if (stream_failed) return;
        if (parse_phase == PH_MAGIC_WS) begin
            if (blank(c)) return;
            match_pos   = 0;
            parse_phase = PH_MAGIC;
        end
        if (parse_phase == PH_FRM_WS) begin
            if (blank(c)) return;
            match_pos   = 0;
            parse_phase = PH_FRM_MATCH;
        end
        case (parse_phase)
            PH_MAGIC: begin
                if (match_pos < magic_text.len()) begin
                    if (c != magic_text[match_pos]) format_error();
                    else match_pos++;
                end else if (c == CH_SPACE) begin
                    parse_phase = PH_HDR_SEL;
                end else if (c == CH_LF) begin
                    close_header();
                end else begin
                    format_error();
                end
            end
            PH_HDR_SEL: begin
                if (c == CH_LF) begin
                    close_header();
                end else if (c != CH_SPACE) begin
                    case (c)
                        CH_UP_W: open_tag(TAG_W, PH_HDR_VAL);
                        CH_UP_H: open_tag(TAG_H, PH_HDR_VAL);
                        CH_UP_C: open_tag(TAG_C, PH_HDR_VAL);
                        CH_UP_I: open_tag(TAG_I, PH_HDR_VAL);
                        CH_UP_F, CH_UP_A, CH_UP_X: open_tag(TAG_SKIP, PH_HDR_VAL);
                        default: format_error();
                    endcase
                end
            end
            PH_FRM_MATCH: begin
                if (match_pos < frame_text.len()) begin
                    if (c != frame_text[match_pos]) format_error();
                    else match_pos++;
                end else if (c == CH_SPACE) begin
                    parse_phase = PH_FRM_SEL;
                end else if (c == CH_LF) begin
                    start_frame();
                end else begin
                    format_error();
                end
            end
            PH_FRM_SEL: begin
                if (c == CH_LF) begin
                    start_frame();
                end else if (c != CH_SPACE) begin
                    case (c)
                        CH_UP_I: open_tag(TAG_I, PH_FRM_VAL);
                        CH_UP_X: open_tag(TAG_SKIP, PH_FRM_VAL);
                        default: format_error();
                    endcase
                end
            end
            PH_HDR_VAL, PH_FRM_VAL: begin
                if (c == CH_SPACE || c == CH_LF) begin
                    if (!close_value()) begin
                        format_error();
                    end else if (c == CH_SPACE) begin
                        if (parse_phase == PH_HDR_VAL) parse_phase = PH_HDR_SEL;
                        else parse_phase = PH_FRM_SEL;
                    end else if (parse_phase == PH_HDR_VAL) begin
                        close_header();
                    end else begin
                        start_frame();
                    end
                end else if (!take_value_byte(c)) begin
                    format_error();
                end
            end
            PH_LUMA: begin
                last_px = (col_count + 1 == width_val) && (row_count + 1 == height_val);
                r               = '0;
                r.kind          = KIND_LUMA;
                r.pixel         = c;
                r.column        = col_count[11:0];
                r.row           = row_count[11:0];
                r.last_of_frame = last_px;
                append_expected(r);
                col_count++;
                if (col_count >= width_val) begin
                    col_count = 0;
                    row_count++;
                end
                if (last_px) begin
                    chroma_count = 0;
                    if (chroma_total != 0) parse_phase = PH_CHROMA;
                    else parse_phase = PH_FRM_WS;
                end
            end
            PH_CHROMA: begin
                chroma_count++;
                if (chroma_count >= chroma_total) parse_phase = PH_FRM_WS;
            end
            default: ;
        endcase
    endfunction

    function string show(t_result r);
        return $sformatf("k%0d p%02h c%0d r%0d l%b w%0d h%0d", r.kind, r.pixel,
                         r.column, r.row, r.last_of_frame, r.frame_width,
                         r.frame_height);
    endfunction

    task report_mismatch(string msg);
        mismatches++;
        $display("MISMATCH: %s", msg);
    endtask

    task check_result(t_result got);
        t_result want;
        string   diff;
        diff = "";
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %s", show(got)));
            return;
        end
        want = expected_results.pop_front();
        if (got.kind !== want.kind) diff = {diff, " kind"};
        if (got.pixel !== want.pixel) diff = {diff, " pixel"};
        if (got.column !== want.column) diff = {diff, " column"};
        if (got.row !== want.row) diff = {diff, " row"};
        if (got.last_of_frame !== want.last_of_frame) diff = {diff, " last_of_frame"};
        if (got.frame_width !== want.frame_width) diff = {diff, " frame_width"};
        if (got.frame_height !== want.frame_height) diff = {diff, " frame_height"};
        if (diff != "") begin
            report_mismatch($sformatf("result %0d differs in%s: got %s, want %s",
                                      results_checked, diff, show(got), show(want)));
        end
        results_checked++;
    endtask
endclass

module tb_y4m_luma_extractor;

    localparam int DIM_LIMIT      = 4096;
    localparam int ITEM_TARGET    = 1000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_kind       o_kind;
    logic [7:0]  o_pixel;
    logic [11:0] o_column;
    logic [11:0] o_row;
    logic        o_last_of_frame;
    logic [12:0] o_frame_width;
    logic [12:0] o_frame_height;

    t_scoreboard   board;
    t_result       seen_result;
    logic [7:0]    stream_bytes[$];
    int            idle_pct = 0;
    int            stall_pct = 0;
    int            idle_cycles = 0;

    y4m_luma_extractor #(
        .MAX_DIM(DIM_LIMIT)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_pixel         (o_pixel),
        .o_column        (o_column),
        .o_row           (o_row),
        .o_last_of_frame (o_last_of_frame),
        .o_frame_width   (o_frame_width),
        .o_frame_height  (o_frame_height)
    );

    always #5 i_clk = ~i_clk;

    task automatic add_byte(input logic [7:0] b);
        stream_bytes.insert(stream_bytes.size(), b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic add_dim(input int unsigned n);
        repeat ($urandom_range(0, 2)) add_byte(CH_ZERO);
        add_text($sformatf("%0d", n));
    endtask

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_VT;
            4: return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    task automatic add_skip_value();
        logic [7:0] b;
        repeat ($urandom_range(0, 4)) begin
            b = 8'($urandom_range(0, 255));
            while (b == CH_SPACE || b == CH_LF) b = 8'($urandom_range(0, 255));
            add_byte(b);
        end
    endtask

    task automatic add_frame_data(input int unsigned w, input int unsigned h);
        repeat (w * h) add_byte(8'($urandom_range(0, 255)));
        repeat ((w * h / 4) * 2) add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic add_random_frame(input int unsigned w, input int unsigned h);
        repeat ($urandom_range(0, 3)) add_byte(blank_char());
        add_text("FRAME");
        repeat ($urandom_range(0, 2)) begin
            repeat ($urandom_range(1, 2)) add_byte(CH_SPACE);
            if ($urandom_range(0, 1)) begin
                add_text("Ip");
            end else begin
                add_byte(CH_UP_X);
                add_skip_value();
            end
        end
        if ($urandom_range(0, 3) == 0) add_byte(CH_SPACE);
        add_byte(CH_LF);
        add_frame_data(w, h);
    endtask

    task automatic build_stream();
        int unsigned w;
        int unsigned h;
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 6);
        if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1)) w = 0;
            else h = 0;
        end
        add_byte(CH_SPACE);
        add_byte(CH_TAB);
        add_byte(CH_LF);
        add_byte(CH_VT);
        add_byte(CH_FF);
        add_byte(CH_CR);
        add_text("YUV4MPEG2 W4096 H0 F30000:1001 A1:1 X C420jpeg  Ip Xq");
        if ($urandom_range(0, 1)) begin
            add_text(" W");
            add_dim(w);
            add_text(" H");
            add_dim(h);
        end else begin
            add_text(" H");
            add_dim(h);
            add_text(" W");
            add_dim(w);
        end
        if ($urandom_range(0, 1)) add_byte(CH_SPACE);
        add_byte(CH_LF);
        add_text("FRAME\n");
        add_frame_data(w, h);
        add_text("\tFRAME Ip X\n");
        add_frame_data(w, h);
        add_text("\r\nFRAME Xa Ip \n");
        add_frame_data(w, h);
        while (stream_bytes.size() < ITEM_TARGET) add_random_frame(w, h);
        case ($urandom_range(0, 5))
            0: add_text("FRAXE\n");
            1: add_text("FRAME W5\n");
            2: add_text("FRAME Iq\n");
            3: add_text("FRAME I \n");
            4: add_text("FRAME\t\n");
            default: add_text("ZFRAME\n");
        endcase
        repeat (30) add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        board.note_byte(b);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                seen_result.kind          = o_kind;
                seen_result.pixel         = o_pixel;
                seen_result.column        = o_column;
                seen_result.row           = o_row;
                seen_result.last_of_frame = o_last_of_frame;
                seen_result.frame_width   = o_frame_width;
                seen_result.frame_height  = o_frame_height;
                board.check_result(seen_result);
            end
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int total;
        board = new(DIM_LIMIT);
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_data_byte <= 8'h00;
        build_stream();
        total = stream_bytes.size();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int idx = 0; idx < total; idx++) begin
            case (idx * 4 / total)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            send_byte(stream_bytes[idx]);
        end
        i_in_valid <= 1'b0;
        while (board.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
